### rtl/llcp_pkg.sv
// shared widths, pipeline constants and helpers for the closest-points pipeline
package llcp_pkg;

    // coordinate and difference widths
    localparam int CW   = 32;
    localparam int DW   = 33;
    // signed dot product terms and sums
    localparam int PW   = 66;
    localparam int SW   = 68;
    // dot magnitude and its halves
    localparam int MW   = 66;
    localparam int HW   = 33;
    // product of two dot magnitudes
    localparam int FW   = 132;
    // signed determinant and numerators
    localparam int NW   = 134;
    // numerator magnitude split into chunks
    localparam int NCH  = 4;
    localparam int CHW  = 34;
    localparam int NMW  = NCH * CHW;
    // scaled numerator, divider remainder width
    localparam int UW   = 170;
    localparam int WR   = 172;
    // quotient bits, one per divider stage
    localparam int QB   = 35;
    // division lanes: three per point, two fractions
    localparam int NL   = 8;
    // pipeline depth: eleven front stages, divider stages, output register
    localparam int DV0  = 11;
    localparam int NSTG = DV0 + QB + 1;

    // operand pairs of the six wide products, indexing the dot products
    // 0 dcb, 1 dba, 2 dca, 3 dbb, 4 daa
    localparam int PX [0:5] = '{4, 1, 0, 2, 0, 2};
    localparam int PY [0:5] = '{3, 1, 1, 3, 4, 1};

    // magnitude of a signed difference
    function automatic logic [DW-1:0] abs_d(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] n;
        n = -v;
        return v[DW-1] ? n : v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [CW-1:0] sat32(input logic signed [35:0] v);
        logic [CW-1:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[CW-1:0];
        return r;
    endfunction

endpackage

### rtl/line_line_closest_points.sv
// 47 register stages lie between an input transfer and out_valid
// throughput: one item per cycle unless held; the 35-stage restoring divider sets depth
// the whole pipeline holds when a result waits and out_ready is low
// reset: all stage valid bits clear, epsilon returns to 1
// data registers carry no reset
module line_line_closest_points (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   p1_x,
    input  logic signed [31:0]   p1_y,
    input  logic signed [31:0]   p1_z,
    input  logic signed [31:0]   p2_x,
    input  logic signed [31:0]   p2_y,
    input  logic signed [31:0]   p2_z,
    input  logic signed [31:0]   p3_x,
    input  logic signed [31:0]   p3_y,
    input  logic signed [31:0]   p3_z,
    input  logic signed [31:0]   p4_x,
    input  logic signed [31:0]   p4_y,
    input  logic signed [31:0]   p4_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic signed [31:0]   near_a_x,
    output logic signed [31:0]   near_a_y,
    output logic signed [31:0]   near_a_z,
    output logic signed [31:0]   near_b_x,
    output logic signed [31:0]   near_b_y,
    output logic signed [31:0]   near_b_z,
    output logic signed [31:0]   frac_a,
    output logic signed [31:0]   frac_b
);

    localparam int DVE = llcp_pkg::DV0 + llcp_pkg::QB;

    logic [15:0]                 eps_reg;
    logic [llcp_pkg::NSTG-1:0]   vld_reg;
    logic                        adv;

    logic signed [31:0]          pin [0:11];

    // front stage registers
    logic signed [llcp_pkg::DW-1:0]  c1_reg [0:2];
    logic [5:0][llcp_pkg::DW-1:0]    ab_reg [1:7];
    logic [5:0][llcp_pkg::DW-1:0]    ab_next;
    logic signed [llcp_pkg::DW-1:0]  c1_next [0:2];
    logic [5:0][31:0]                base_reg [1:DVE];
    logic [5:0][31:0]                base_next;

    logic signed [llcp_pkg::PW-1:0]  prod2_reg [0:14];
    logic signed [llcp_pkg::PW-1:0]  prod2_next [0:14];
    logic                            tiny_reg [2:7];
    logic                            tiny_next;

    logic signed [llcp_pkg::SW-1:0]  dot3_reg [0:4];
    logic signed [llcp_pkg::SW-1:0]  dot3_next [0:4];

    logic [llcp_pkg::MW-1:0]         mag4_reg [0:4];
    logic [llcp_pkg::MW-1:0]         mag4_next [0:4];
    logic                            sgn4_reg [0:4];
    logic                            sgn4_next [0:4];

    logic [llcp_pkg::PW-1:0]         pp5_reg [0:5][0:3];
    logic [llcp_pkg::PW-1:0]         pp5_next [0:5][0:3];
    logic                            sg5_reg [0:5];
    logic                            sg5_next [0:5];

    logic [llcp_pkg::FW-1:0]         full6_reg [0:5];
    logic [llcp_pkg::FW-1:0]         full6_next [0:5];
    logic                            sg6_reg [0:5];

    logic signed [llcp_pkg::NW-1:0]  d7_reg, n7_reg, m7_reg;
    logic signed [llcp_pkg::NW-1:0]  d7_next, n7_next, m7_next;

    logic [llcp_pkg::NMW-1:0]        magn8_reg, magm8_reg;
    logic [llcp_pkg::NMW-1:0]        magn8_next, magm8_next;
    logic                            sgn8_reg, sgm8_reg;
    logic [llcp_pkg::NW-1:0]         d8_reg;
    logic [5:0][llcp_pkg::DW-1:0]    am8_reg;
    logic [5:0][llcp_pkg::DW-1:0]    am8_next;
    logic [5:0]                      sa8_reg;
    logic                            found8_next;
    logic                            found_reg [8:DVE];

    logic [llcp_pkg::CHW+llcp_pkg::DW-1:0] pp9_reg [0:5][0:llcp_pkg::NCH-1];
    logic [llcp_pkg::CHW+llcp_pkg::DW-1:0] pp9_next [0:5][0:llcp_pkg::NCH-1];
    logic [llcp_pkg::NMW-1:0]        fr9_reg [0:1];
    logic [llcp_pkg::NW-1:0]         d9_reg, d10_reg;
    logic [llcp_pkg::NL-1:0]         neg_reg [9:DVE];
    logic [llcp_pkg::NL-1:0]         neg9_next;

    logic [llcp_pkg::UW-1:0]         num10_reg [0:llcp_pkg::NL-1];
    logic [llcp_pkg::UW-1:0]         num10_next [0:llcp_pkg::NL-1];

    // divider stages: index 0 is the remainder seed, index QB the finished quotient
    logic [llcp_pkg::WR-1:0]         dv_rem_reg [0:llcp_pkg::QB][0:llcp_pkg::NL-1];
    logic [llcp_pkg::WR-1:0]         dv_rem_next [0:llcp_pkg::QB][0:llcp_pkg::NL-1];
    logic [llcp_pkg::QB-1:0]         dv_q_reg [0:llcp_pkg::QB][0:llcp_pkg::NL-1];
    logic [llcp_pkg::QB-1:0]         dv_q_next [0:llcp_pkg::QB][0:llcp_pkg::NL-1];
    logic [llcp_pkg::WR-1:0]         dv_y_reg [0:llcp_pkg::QB];
    logic [llcp_pkg::WR-1:0]         dv_y_next [0:llcp_pkg::QB];

    // output register
    logic                            found_out_reg;
    logic [31:0]                     res_reg [0:llcp_pkg::NL-1];
    logic [31:0]                     res_next [0:llcp_pkg::NL-1];

    // global advance: the output register is free or its transfer happens now
    assign adv       = !vld_reg[llcp_pkg::NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[llcp_pkg::NSTG-1];

    assign pin[0]  = p1_x;  assign pin[1]  = p1_y;  assign pin[2]  = p1_z;
    assign pin[3]  = p2_x;  assign pin[4]  = p2_y;  assign pin[5]  = p2_z;
    assign pin[6]  = p3_x;  assign pin[7]  = p3_y;  assign pin[8]  = p3_z;
    assign pin[9]  = p4_x;  assign pin[10] = p4_y;  assign pin[11] = p4_z;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= 16'd1;
        else if (cfg_we)
            eps_reg <= cfg_data;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[llcp_pkg::NSTG-2:0], in_valid};
    end

    // stage 1: direction vectors and offset between the lines
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab_next[i]     = llcp_pkg::DW'(pin[3+i]) - llcp_pkg::DW'(pin[i]);
            ab_next[3+i]   = llcp_pkg::DW'(pin[9+i]) - llcp_pkg::DW'(pin[6+i]);
            c1_next[i]     = llcp_pkg::DW'(pin[i]) - llcp_pkg::DW'(pin[6+i]);
            base_next[i]   = pin[i];
            base_next[3+i] = pin[6+i];
        end
    end

    // stage 2: dot product terms and degenerate direction test
    always_comb
    begin
        logic signed [llcp_pkg::DW-1:0] av [0:2];
        logic signed [llcp_pkg::DW-1:0] bv [0:2];
        logic ta, tb;
        ta = 1'b1;
        tb = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            av[i] = ab_reg[1][i];
            bv[i] = ab_reg[1][3+i];
        end
        for (int i = 0; i < 3; i++)
        begin
            prod2_next[i]    = c1_reg[i] * bv[i];
            prod2_next[3+i]  = bv[i] * av[i];
            prod2_next[6+i]  = c1_reg[i] * av[i];
            prod2_next[9+i]  = bv[i] * bv[i];
            prod2_next[12+i] = av[i] * av[i];
            ta = ta && (llcp_pkg::abs_d(av[i]) < {17'd0, eps_reg});
            tb = tb && (llcp_pkg::abs_d(bv[i]) < {17'd0, eps_reg});
        end
        tiny_next = ta || tb;
    end

    // stage 3: dot product sums
    always_comb
    begin
        for (int t = 0; t < 5; t++)
            dot3_next[t] = llcp_pkg::SW'(prod2_reg[3*t]) + llcp_pkg::SW'(prod2_reg[3*t+1])
                         + llcp_pkg::SW'(prod2_reg[3*t+2]);
    end

    // stage 4: sign and magnitude of each dot product
    always_comb
    begin
        logic signed [llcp_pkg::SW-1:0] ng;
        for (int t = 0; t < 5; t++)
        begin
            ng           = -dot3_reg[t];
            sgn4_next[t] = dot3_reg[t][llcp_pkg::SW-1];
            mag4_next[t] = sgn4_next[t] ? ng[llcp_pkg::MW-1:0] : dot3_reg[t][llcp_pkg::MW-1:0];
        end
    end

    // stage 5: half-width partial products of the six wide products
    always_comb
    begin
        logic [llcp_pkg::HW-1:0] xh [0:1];
        logic [llcp_pkg::HW-1:0] yh [0:1];
        for (int j = 0; j < 6; j++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                xh[h] = mag4_reg[llcp_pkg::PX[j]][llcp_pkg::HW*h +: llcp_pkg::HW];
                yh[h] = mag4_reg[llcp_pkg::PY[j]][llcp_pkg::HW*h +: llcp_pkg::HW];
            end
            for (int h = 0; h < 2; h++)
                for (int l = 0; l < 2; l++)
                    pp5_next[j][2*h+l] = llcp_pkg::PW'(xh[h]) * llcp_pkg::PW'(yh[l]);
            sg5_next[j] = sgn4_reg[llcp_pkg::PX[j]] ^ sgn4_reg[llcp_pkg::PY[j]];
        end
    end

    // stage 6: assemble the wide products
    always_comb
    begin
        for (int j = 0; j < 6; j++)
            full6_next[j] = llcp_pkg::FW'(pp5_reg[j][0])
                          + (llcp_pkg::FW'(pp5_reg[j][1]) << llcp_pkg::HW)
                          + (llcp_pkg::FW'(pp5_reg[j][2]) << llcp_pkg::HW)
                          + (llcp_pkg::FW'(pp5_reg[j][3]) << (2 * llcp_pkg::HW));
    end

    // stage 7: determinant and the two numerators
    always_comb
    begin
        logic signed [llcp_pkg::NW-1:0] sv [0:5];
        for (int j = 0; j < 6; j++)
            sv[j] = sg6_reg[j] ? -$signed(llcp_pkg::NW'(full6_reg[j]))
                               : $signed(llcp_pkg::NW'(full6_reg[j]));
        d7_next = sv[0] - sv[1];
        n7_next = sv[2] - sv[3];
        m7_next = sv[4] - sv[5];
    end

    // stage 8: numerator magnitudes, direction magnitudes, solution test
    always_comb
    begin
        logic signed [llcp_pkg::NW-1:0] nn, nm;
        logic [llcp_pkg::NW-1:0] lim;
        nn  = -n7_reg;
        nm  = -m7_reg;
        magn8_next = llcp_pkg::NMW'(n7_reg[llcp_pkg::NW-1] ? nn : n7_reg);
        magm8_next = llcp_pkg::NMW'(m7_reg[llcp_pkg::NW-1] ? nm : m7_reg);
        lim = llcp_pkg::NW'(eps_reg) << 48;
        found8_next = !tiny_reg[7] && (d7_reg != '0) && ($unsigned(d7_reg) >= lim);
        for (int i = 0; i < 6; i++)
            am8_next[i] = llcp_pkg::abs_d(ab_reg[7][i]);
    end

    // stage 9: chunked products of numerator and direction components
    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            for (int k = 0; k < llcp_pkg::NCH; k++)
                pp9_next[l][k] = llcp_pkg::CHW'(l < 3 ? magn8_reg[llcp_pkg::CHW*k +: llcp_pkg::CHW]
                                                      : magm8_reg[llcp_pkg::CHW*k +: llcp_pkg::CHW])
                                 * llcp_pkg::DW'(am8_reg[l]);
            neg9_next[l] = (l < 3 ? sgn8_reg : sgm8_reg) ^ sa8_reg[l];
        end
        neg9_next[6] = sgn8_reg;
        neg9_next[7] = sgm8_reg;
    end

    // stage 10: sum the chunks; fractions are the numerators in Q16.16
    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            num10_next[l] = '0;
            for (int k = 0; k < llcp_pkg::NCH; k++)
                num10_next[l] = num10_next[l]
                              + (llcp_pkg::UW'(pp9_reg[l][k]) << (llcp_pkg::CHW * k));
        end
        num10_next[6] = llcp_pkg::UW'(fr9_reg[0]) << 16;
        num10_next[7] = llcp_pkg::UW'(fr9_reg[1]) << 16;
    end

    // divider: seed with 2n+d over 2d, then one quotient bit per stage
    always_comb
    begin
        logic [llcp_pkg::WR-1:0] sh;
        dv_y_next[0] = llcp_pkg::WR'(d10_reg) << 1;
        for (int l = 0; l < llcp_pkg::NL; l++)
        begin
            dv_rem_next[0][l] = (llcp_pkg::WR'(num10_reg[l]) << 1) + llcp_pkg::WR'(d10_reg);
            dv_q_next[0][l]   = '0;
        end
        for (int k = 0; k < llcp_pkg::QB; k++)
        begin
            dv_y_next[k+1] = dv_y_reg[k];
            sh = dv_y_reg[k] << (llcp_pkg::QB - 1 - k);
            for (int l = 0; l < llcp_pkg::NL; l++)
            begin
                if (dv_rem_reg[k][l] >= sh)
                begin
                    dv_rem_next[k+1][l] = dv_rem_reg[k][l] - sh;
                    dv_q_next[k+1][l]   = {dv_q_reg[k][l][llcp_pkg::QB-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k+1][l] = dv_rem_reg[k][l];
                    dv_q_next[k+1][l]   = {dv_q_reg[k][l][llcp_pkg::QB-2:0], 1'b0};
                end
            end
        end
    end

    // output stage: clamp quotient, apply sign, add base point, saturate
    always_comb
    begin
        logic [llcp_pkg::QB-1:0] q;
        logic [33:0] m;
        logic signed [35:0] val, bs;
        for (int l = 0; l < llcp_pkg::NL; l++)
        begin
            q   = dv_q_reg[llcp_pkg::QB][l];
            m   = (q[llcp_pkg::QB-1] || q[llcp_pkg::QB-2]) ? 34'h2_0000_0000 : {1'b0, q[32:0]};
            val = neg_reg[DVE][l] ? -$signed({2'b00, m}) : $signed({2'b00, m});
            bs  = (l < 6) ? 36'($signed(base_reg[DVE][l])) : 36'sd0;
            res_next[l] = found_reg[DVE] ? llcp_pkg::sat32(bs + val) : 32'd0;
        end
    end

    // data registers, all moving on the common advance
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // front stages
            c1_reg      <= c1_next;
            ab_reg[1]   <= ab_next;
            base_reg[1] <= base_next;
            for (int s = 2; s <= 7; s++)
                ab_reg[s] <= ab_reg[s-1];
            for (int s = 2; s <= DVE; s++)
                base_reg[s] <= base_reg[s-1];
            prod2_reg   <= prod2_next;
            tiny_reg[2] <= tiny_next;
            for (int s = 3; s <= 7; s++)
                tiny_reg[s] <= tiny_reg[s-1];
            dot3_reg    <= dot3_next;
            mag4_reg    <= mag4_next;
            sgn4_reg    <= sgn4_next;
            pp5_reg     <= pp5_next;
            sg5_reg     <= sg5_next;
            full6_reg   <= full6_next;
            sg6_reg     <= sg5_reg;
            d7_reg      <= d7_next;
            n7_reg      <= n7_next;
            m7_reg      <= m7_next;
            magn8_reg   <= magn8_next;
            magm8_reg   <= magm8_next;
            sgn8_reg    <= n7_reg[llcp_pkg::NW-1];
            sgm8_reg    <= m7_reg[llcp_pkg::NW-1];
            d8_reg      <= d7_reg;
            am8_reg     <= am8_next;
            for (int i = 0; i < 6; i++)
                sa8_reg[i] <= ab_reg[7][i][llcp_pkg::DW-1];
            found_reg[8] <= found8_next;
            for (int s = 9; s <= DVE; s++)
                found_reg[s] <= found_reg[s-1];
            pp9_reg     <= pp9_next;
            fr9_reg[0]  <= magn8_reg;
            fr9_reg[1]  <= magm8_reg;
            d9_reg      <= d8_reg;
            neg_reg[9]  <= neg9_next;
            for (int s = 10; s <= DVE; s++)
                neg_reg[s] <= neg_reg[s-1];
            num10_reg   <= num10_next;
            d10_reg     <= d9_reg;
            // divider
            dv_rem_reg  <= dv_rem_next;
            dv_q_reg    <= dv_q_next;
            dv_y_reg    <= dv_y_next;
            // output
            found_out_reg <= found_reg[DVE];
            res_reg       <= res_next;
        end
    end

    assign found    = found_out_reg;
    assign near_a_x = res_reg[0];
    assign near_a_y = res_reg[1];
    assign near_a_z = res_reg[2];
    assign near_b_x = res_reg[3];
    assign near_b_y = res_reg[4];
    assign near_b_z = res_reg[5];
    assign frac_a   = res_reg[6];
    assign frac_b   = res_reg[7];

endmodule
